/* design/aarm_pkg.sv */
// Shared constants and helpers for the axis-angle rotation matrix core.
package aarm_pkg;

  localparam int Stages  = 16;
  localparam int Latency = Stages + 4;
  localparam int CW      = 34;
  localparam int AW      = 72;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30  = 34'sd1073741824;

  localparam logic signed [CW-1:0] ATAN [Stages] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D
  };

  typedef logic signed [15:0] q16_t;

  function automatic q16_t round_sat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    q16_t                 r;
    t = (v + (72'sd1 <<< 45)) >>> 46;
    if (t > 72'sd32767) begin
      r = 16'sh7FFF;
    end else if (t < -72'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = 16'(t);
    end
    return r;
  endfunction

endpackage

/* design/axis_angle_rotation_matrix_core.sv */
// done follows an accepted start through the fold register, the CORDIC stages and stages A, B and C.
// Throughput: one beat per cycle; one CORDIC stage per register stage.
// busy is high only during reset; the receiver cannot stall, so results
// are shown for exactly one cycle with done.
// Reset (rst, synchronous) clears all pipeline valid bits.
// Top level: quadrant fold, 16-stage CORDIC, product and Rodrigues sum stages.
module axis_angle_rotation_matrix_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic        [15:0] angle,
  output logic        done,
  output logic signed [15:0] r00,
  output logic signed [15:0] r01,
  output logic signed [15:0] r02,
  output logic signed [15:0] r10,
  output logic signed [15:0] r11,
  output logic signed [15:0] r12,
  output logic signed [15:0] r20,
  output logic signed [15:0] r21,
  output logic signed [15:0] r22
);

  localparam int N  = aarm_pkg::Stages;
  localparam int CW = aarm_pkg::CW;
  localparam int AW = aarm_pkg::AW;

  assign busy = rst;

  logic                 cv   [N+1];
  logic signed [CW-1:0] cx   [N+1];
  logic signed [CW-1:0] cy   [N+1];
  logic signed [CW-1:0] cz   [N+1];
  logic                 cf   [N+1];
  logic signed [15:0]   cax  [N+1];
  logic signed [15:0]   cay  [N+1];
  logic signed [15:0]   caz  [N+1];

  // quadrant fold
  logic               flip;
  logic signed [15:0] res;
  assign flip = angle[15] ^ angle[14];
  assign res  = flip ? $signed({~angle[15], angle[14:0]}) : $signed(angle);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= start;
    end
    cx[0]  <= aarm_pkg::GAIN_Q30;
    cy[0]  <= '0;
    cz[0]  <= CW'(res) <<< 16;
    cf[0]  <= flip;
    cax[0] <= axis_x;
    cay[0] <= axis_y;
    caz[0] <= axis_z;
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - aarm_pkg::ATAN[i];
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + aarm_pkg::ATAN[i];
      end
      cf[i+1]  <= cf[i];
      cax[i+1] <= cax[i];
      cay[i+1] <= cay[i];
      caz[i+1] <= caz[i];
    end
  end

  // stage A: sign fix, pair products
  logic                 av;
  logic signed [CW-1:0] ac, as;
  logic signed [CW:0]   aomc;
  logic signed [31:0]   axx, ayy, azz, axy, axz, ayz;
  logic signed [15:0]   aax, aay, aaz;

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else begin
      av <= cv[N];
    end
    ac   <= cf[N] ? -cx[N] : cx[N];
    as   <= cf[N] ? -cy[N] : cy[N];
    aomc <= (CW+1)'(aarm_pkg::ONE_Q30) - (cf[N] ? -(CW+1)'(cx[N]) : (CW+1)'(cx[N]));
    axx  <= 32'(cax[N] * cax[N]);
    ayy  <= 32'(cay[N] * cay[N]);
    azz  <= 32'(caz[N] * caz[N]);
    axy  <= 32'(cax[N] * cay[N]);
    axz  <= 32'(cax[N] * caz[N]);
    ayz  <= 32'(cay[N] * caz[N]);
    aax  <= cax[N];
    aay  <= cay[N];
    aaz  <= caz[N];
  end

  // stage B: wide products
  logic                 bv;
  logic signed [31:0]   bxx, byy, bzz;
  logic signed [AW-1:0] bdx, bdy, bdz, bxy, bxz, byz, bsx, bsy, bsz;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else begin
      bv <= av;
    end
    bxx <= axx;
    byy <= ayy;
    bzz <= azz;
    bdx <= AW'((32'sd1073741824 - axx) * ac);
    bdy <= AW'((32'sd1073741824 - ayy) * ac);
    bdz <= AW'((32'sd1073741824 - azz) * ac);
    bxy <= AW'(axy * aomc);
    bxz <= AW'(axz * aomc);
    byz <= AW'(ayz * aomc);
    bsx <= AW'(aax * as);
    bsy <= AW'(aay * as);
    bsz <= AW'(aaz * as);
  end

  // stage C: sums, round, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= bv;
    end
    r00 <= aarm_pkg::round_sat((AW'(bxx) <<< 30) + bdx);
    r11 <= aarm_pkg::round_sat((AW'(byy) <<< 30) + bdy);
    r22 <= aarm_pkg::round_sat((AW'(bzz) <<< 30) + bdz);
    r01 <= aarm_pkg::round_sat(bxy - (bsz <<< 15));
    r10 <= aarm_pkg::round_sat(bxy + (bsz <<< 15));
    r02 <= aarm_pkg::round_sat(bxz + (bsy <<< 15));
    r20 <= aarm_pkg::round_sat(bxz - (bsy <<< 15));
    r12 <= aarm_pkg::round_sat(byz - (bsx <<< 15));
    r21 <= aarm_pkg::round_sat(byz + (bsx <<< 15));
  end

endmodule

/* design/aarm_checker.sv */
// Port-level checker for the rotation matrix core, with its bind.
module aarm_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] axis_x,
  input logic signed [15:0] axis_y,
  input logic signed [15:0] axis_z,
  input logic               done,
  input logic signed [15:0] r01,
  input logic signed [15:0] r10,
  input logic signed [15:0] r02,
  input logic signed [15:0] r20
);

  localparam int Lat = aarm_pkg::Latency;

  a_beat_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Lat done)
    else $error("accepted beat produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Lat))
    else $error("result without an accepted beat");

  a_zero_axis: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && axis_x == 16'sd0 && axis_y == 16'sd0 && axis_z == 16'sd0)
      |-> ##Lat (r01 == 16'sd0 && r10 == 16'sd0 && r02 == 16'sd0 && r20 == 16'sd0))
    else $error("zero axis gave nonzero off-diagonal entries");

endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
  .done(done), .r01(r01), .r10(r10), .r02(r02), .r20(r20)
);

/* tb/sv/axis_angle_rotation_matrix_core_test.sv */
// Self-checking testbench for the axis-angle rotation matrix core.
module axis_angle_rotation_matrix_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [15:0] ax, ay, az;
    logic        [15:0] ang;
    bit                 known;
    logic signed [15:0] m [9];
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic [15:0] angle = '0;
  logic busy, done;
  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  matrix_t pending_matrices [$];
  int      errors = 0;
  longint  cycle_count = 0;
  int      send_idle_pct = 0;

  axis_angle_rotation_matrix_core u_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint asr(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic logic signed [15:0] sat_q14(longint v);
    longint t;
    t = (v + (64'sd1 <<< 45)) >>> 46;
    if (t > 32767) return 16'sh7FFF;
    if (t < -32768) return 16'sh8000;
    return 16'(t);
  endfunction

  function automatic matrix_t rodrigues_matrix(logic signed [15:0] ax, logic signed [15:0] ay,
                                               logic signed [15:0] az, logic [15:0] ang);
    longint tab [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    longint a, x, y, z, nx, c, s, omc, one, xx, yy, zz, xy, xz, yz, sx, sy, sz;
    longint lx, ly, lz;
    bit flip;
    matrix_t r;
    one = 64'sd1073741824;
    a = ang;
    flip = 0;
    if (a >= 16384 && a < 49152) begin
      a -= 32768;
      flip = 1;
    end else if (a >= 49152) begin
      a -= 65536;
    end
    z = a * 65536;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        z -= tab[i];
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        z += tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    omc = one - c;
    lx = ax; ly = ay; lz = az;
    xx = lx * lx; yy = ly * ly; zz = lz * lz;
    xy = lx * ly; xz = lx * lz; yz = ly * lz;
    sx = lx * 32768 * s; sy = ly * 32768 * s; sz = lz * 32768 * s;
    r.m[0] = sat_q14(xx * one + (one - xx) * c);
    r.m[1] = sat_q14(xy * omc - sz);
    r.m[2] = sat_q14(xz * omc + sy);
    r.m[3] = sat_q14(xy * omc + sz);
    r.m[4] = sat_q14(yy * one + (one - yy) * c);
    r.m[5] = sat_q14(yz * omc - sx);
    r.m[6] = sat_q14(xz * omc - sy);
    r.m[7] = sat_q14(yz * omc + sx);
    r.m[8] = sat_q14(zz * one + (one - zz) * c);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    matrix_t want;
    logic signed [15:0] got [9];
    if (!rst && done) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected beat", 0, 0);
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < 9; i++)
          if (got[i] !== want.m[i]) report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                                    got[i], want.m[i]);
      end
    end
  end

  task automatic send_beat(stim_t st);
    matrix_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    want = rodrigues_matrix(st.ax, st.ay, st.az, st.ang);
    if (st.known) begin
      for (int i = 0; i < 9; i++)
        if (want.m[i] !== st.m[i]) report_mismatch("table entry", want.m[i], st.m[i]);
    end
    start  <= 1'b1;
    axis_x <= st.ax;
    axis_y <= st.ay;
    axis_z <= st.az;
    angle  <= st.ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_matrices.insert(pending_matrices.size(), want);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_axis(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 6)) == 0 ? 16'sh8000 : 16'sh7FFF;
      default: return 16'($signed($urandom_range(0, 46340)) - 23170);
    endcase
  endfunction

  stim_t directed [] = '{
    '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'h0000, 1'b0, '{default: 0}},
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'h0000, 1'b1,
      '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b0, '{default: 0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 16'h8000, 1'b0, '{default: 0}},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, 1'b0, '{default: 0}},
    '{16'sh0000, 16'sh0000, 16'sh7FFF, 16'h4000, 1'b0, '{default: 0}},
    '{16'sh0000, 16'sh7FFF, 16'sh0000, 16'h3FFF, 1'b0, '{default: 0}},
    '{16'sh7FFF, 16'sh0000, 16'sh0000, 16'hBFFF, 1'b0, '{default: 0}},
    '{16'sh0000, 16'sh0000, 16'sh8000, 16'hC000, 1'b0, '{default: 0}},
    '{16'sh49E7, 16'sh49E7, 16'sh49E7, 16'h2000, 1'b0, '{default: 0}},
    '{16'sh1234, 16'shEDCB, 16'sh5A5A, 16'hA5A5, 1'b0, '{default: 0}},
    '{16'sh0100, 16'sh0010, 16'sh0001, 16'h5555, 1'b0, '{default: 0}}
  };

  initial begin
    stim_t st;
    int pct [4] = '{0, 64, 0, 16};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) send_beat(directed[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = pct[ph];
      for (int n = 0; n < 450; n++) begin
        st.known = 0;
        st.ax = rand_axis(n % 5 == 0 ? 1 : (n % 3 == 0 ? 0 : 2));
        st.ay = rand_axis(n % 7 == 0 ? 1 : (n % 4 == 0 ? 0 : 2));
        st.az = rand_axis(n % 11 == 0 ? 1 : (n % 2 == 0 ? 0 : 2));
        st.ang = 16'($urandom);
        if (n % 50 == 0) st.ang = 16'($urandom_range(0, 3)) * 16'h4000
                                  + 16'($urandom_range(0, 2)) - 16'd1;
        send_beat(st);
        if (n == 200) begin
          start <= 1'b0;
          while (pending_matrices.size() != 0) @(negedge clk);
        end
      end
    end
    start <= 1'b0;
    while (pending_matrices.size() != 0) @(negedge clk);
    repeat (aarm_pkg::Latency + 10) @(negedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/aarm_pkg.sv
design/axis_angle_rotation_matrix_core.sv
design/aarm_checker.sv
tb/sv/axis_angle_rotation_matrix_core_test.sv
